// ===== rtl/fsnf_pkg.sv =====
// ----------------------------------------------------------------------------
// fsnf_pkg: shared types and constants of the short name formatter
// Holds the 8.3 name layout, the character codes and the phase type.
// ----------------------------------------------------------------------------
package fsnf_pkg;

   // Layout of the 11-byte directory name.
   localparam int NAME_BYTES = 11;
   localparam int EXT_START  = 8;
   localparam int POS_W      = 4;

   localparam logic [POS_W-1:0] LAST_POS = POS_W'(NAME_BYTES - 1);

   // Character codes.
   localparam logic [7:0] SPACE_CODE = 8'h20;
   localparam logic [7:0] DOT_CODE   = 8'h2E;
   localparam logic [7:0] LOWER_A    = 8'h61;
   localparam logic [7:0] LOWER_Z    = 8'h7A;
   localparam logic [7:0] CASE_DIFF  = 8'd32;
   localparam logic [7:0] END_CODE   = 8'h00;

   // One full 8.3 name, byte 0 in the low lane.
   typedef logic [NAME_BYTES-1:0][7:0] name_type;

   // Parser phase.
   typedef enum logic [1:0] {
      PH_BASE = 2'd0,
      PH_EXT  = 2'd1,
      PH_DONE = 2'd2
   } phase_type;

   // Lower-case letters become upper case; every other byte passes unchanged.
   function automatic logic [7:0] to_upper(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c inside {[LOWER_A:LOWER_Z]}) begin
         r = c - CASE_DIFF;
      end
      return r;
   endfunction

endpackage

// ===== rtl/fsnf_build.sv =====
// ----------------------------------------------------------------------------
// fsnf_build: name builder
// Tracks the parse phase and writes accepted characters that fit into the 11-byte
// name register; an end-of-name beat returns everything to all spaces.
// ----------------------------------------------------------------------------
module fsnf_build #(
   parameter int BASE_LEN = 8,
   parameter int EXT_LEN  = 3
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic               flush,
   input  logic [7:0]         char_byte,
   output fsnf_pkg::name_type name
);
   import fsnf_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [3:0] base_count_ff, base_count_in;
   logic [1:0] ext_count_ff, ext_count_in;
   name_type   store_ff, store_in;

   logic       wr_en;
   logic [3:0] wr_idx;
   logic       base_room;
   logic       ext_room;
   logic [1:0] ext_next;

   assign base_room = base_count_ff < 4'(BASE_LEN);
   assign ext_room  = ext_count_ff < 2'(EXT_LEN);
   assign ext_next  = ext_count_ff + 2'd1;

   // Next phase and counters for one character beat.
   always_comb begin
      phase_in      = phase_ff;
      base_count_in = base_count_ff;
      ext_count_in  = ext_count_ff;
      if (flush) begin
         phase_in      = PH_BASE;
         base_count_in = 4'd0;
         ext_count_in  = 2'd0;
      end else if (step) begin
         case (phase_ff)
            PH_BASE: begin
               if (char_byte == DOT_CODE) begin
                  phase_in = PH_EXT;
               end else if (char_byte == SPACE_CODE) begin
                  phase_in = PH_DONE;
               end else if (base_room) begin
                  base_count_in = base_count_ff + 4'd1;
               end
            end
            PH_EXT: begin
               if (char_byte == SPACE_CODE) begin
                  phase_in = PH_DONE;
               end else if (ext_room) begin
                  ext_count_in = ext_next;
                  if (ext_next == 2'(EXT_LEN)) begin
                     phase_in = PH_DONE;
                  end
               end else begin
                  phase_in = PH_DONE;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   // Store write strobe and address for one character beat.
   always_comb begin
      wr_en  = 1'b0;
      wr_idx = base_count_ff;
      case (phase_ff)
         PH_BASE: begin
            wr_en  = step && base_room && (char_byte != DOT_CODE)
                     && (char_byte != SPACE_CODE);
            wr_idx = base_count_ff;
         end
         PH_EXT: begin
            wr_en  = step && ext_room && (char_byte != SPACE_CODE);
            wr_idx = 4'(EXT_START) + {2'b00, ext_count_ff};
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   // Name register update.
   always_comb begin
      store_in = store_ff;
      if (flush) begin
         store_in = {NAME_BYTES{SPACE_CODE}};
      end else if (wr_en) begin
         store_in[wr_idx] = to_upper(char_byte);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_BASE;
         base_count_ff <= 4'd0;
         ext_count_ff  <= 2'd0;
         store_ff      <= {NAME_BYTES{SPACE_CODE}};
      end else begin
         phase_ff      <= phase_in;
         base_count_ff <= base_count_in;
         ext_count_ff  <= ext_count_in;
         store_ff      <= store_in;
      end
   end

   assign name = store_ff;

endmodule

// ===== rtl/fsnf_emit.sv =====
// ----------------------------------------------------------------------------
// fsnf_emit: name emitter
// Captures a finished name and shifts it out one byte per result beat,
// with its position and a flag on the eleventh byte.
// ----------------------------------------------------------------------------
module fsnf_emit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  fsnf_pkg::name_type        name,
   output logic                      load_ok,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [7:0]                rsp_short_name_byte,
   output logic [fsnf_pkg::POS_W-1:0] rsp_byte_position,
   output logic                      rsp_last_byte
);
   import fsnf_pkg::*;

   logic             busy_ff, busy_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   name_type         buf_ff, buf_in;
   logic             fire;
   logic             done;

   assign fire    = busy_ff && !rsp_stall;
   assign done    = fire && (pos_ff == LAST_POS);
   assign load_ok = !busy_ff || done;

   // Control: a new name may load in the cycle the last byte leaves.
   always_comb begin
      busy_in = busy_ff;
      pos_in  = pos_ff;
      if (load) begin
         busy_in = 1'b1;
         pos_in  = '0;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (fire) begin
         pos_in = pos_ff + POS_W'(1);
      end
   end

   // Payload: byte 0 of the shift register is the byte on the port.
   always_comb begin
      buf_in = buf_ff;
      if (load) begin
         buf_in = name;
      end else if (fire) begin
         buf_in = {SPACE_CODE, buf_ff[NAME_BYTES-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pos_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         pos_ff  <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
   end

   assign rsp_valid           = busy_ff;
   assign rsp_short_name_byte = buf_ff[0];
   assign rsp_byte_position   = pos_ff;
   assign rsp_last_byte       = (pos_ff == LAST_POS);

endmodule

// ===== rtl/fat_short_name_formatter_unit.sv =====
// ----------------------------------------------------------------------------
// fat_short_name_formatter_unit: FAT 8.3 short name formatter
// Accepts one name byte per cycle; non-zero bytes cause no result.
// A zero byte emits 11 result beats, the first in the cycle after it is taken.
// The name register frees at once, so the next name streams in meanwhile;
// a zero byte stalls only while the previous name is still being emitted.
// Synchronous reset returns to the base phase with an all-space name.
// ----------------------------------------------------------------------------
module fat_short_name_formatter_unit #(
   parameter int BASE_LEN = 8,
   parameter int EXT_LEN  = 3
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [7:0]                 req_name_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [7:0]                 rsp_short_name_byte,
   output logic [fsnf_pkg::POS_W-1:0] rsp_byte_position,
   output logic                       rsp_last_byte
);
   import fsnf_pkg::*;

   logic     is_end;
   logic     load_ok;
   logic     req_fire;
   logic     step;
   logic     flush;
   name_type name;

   // Only an end-of-name beat waits for the emitter.
   assign is_end    = (req_name_byte == END_CODE);
   assign req_stall = is_end && !load_ok;
   assign req_fire  = req_valid && !req_stall;
   assign step      = req_fire && !is_end;
   assign flush     = req_fire && is_end;

   fsnf_build #(
      .BASE_LEN (BASE_LEN),
      .EXT_LEN  (EXT_LEN)
   ) u_build (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .flush     (flush),
      .char_byte (req_name_byte),
      .name      (name)
   );

   fsnf_emit u_emit (
      .clock               (clock),
      .reset               (reset),
      .load                (flush),
      .name                (name),
      .load_ok             (load_ok),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_short_name_byte (rsp_short_name_byte),
      .rsp_byte_position   (rsp_byte_position),
      .rsp_last_byte       (rsp_last_byte)
   );

endmodule

// ===== rtl/fsnf_check.sv =====
// ----------------------------------------------------------------------------
// fsnf_check: port checker for the short name formatter
// Watches the result channel for ordered, complete 11-beat names.
// ----------------------------------------------------------------------------
module fsnf_check (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic [7:0]                 rsp_short_name_byte,
   input logic [fsnf_pkg::POS_W-1:0] rsp_byte_position,
   input logic                       rsp_last_byte
);
   import fsnf_pkg::*;

   // A stalled result beat holds its byte.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_short_name_byte))
      else $error("stalled result beat changed");

   // The last flag marks exactly the eleventh byte.
   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_byte == (rsp_byte_position == LAST_POS)))
      else $error("last flag does not match position");

   // Within a name the next beat follows at once with the next position.
   a_pos_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_byte |=>
         rsp_valid && (rsp_byte_position == $past(rsp_byte_position) + POS_W'(1)))
      else $error("result beats out of order");

   // No result beat is shown right after reset.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat valid after reset");

endmodule

bind fat_short_name_formatter_unit fsnf_check u_fsnf_check (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_short_name_byte (rsp_short_name_byte),
   .rsp_byte_position   (rsp_byte_position),
   .rsp_last_byte       (rsp_last_byte)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: FAT 8.3 short name formatter
// Streams file names byte by byte into the formatter. A local prediction of
// the 11-byte directory name is queued on every accepted end byte. Each
// emitted beat is checked against the oldest queued byte. Stimulus runs from
// directed corner names through random names and byte noise, with random
// sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
   import fsnf_pkg::*;

   localparam int BASE_LEN     = 8;
   localparam int EXT_LEN      = 3;
   localparam int QUIET_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 20;
   localparam int TOTAL_BYTES  = 370;

   typedef struct {
      logic [7:0]       char_code;
      logic [POS_W-1:0] position;
      logic             last;
   } name_beat_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic [7:0]       req_name_byte = 8'h00;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic [7:0]       rsp_short_name_byte;
   logic [POS_W-1:0] rsp_byte_position;
   logic             rsp_last_byte;

   // Predicted formatter state.
   phase_type        pred_phase;
   logic [3:0]       pred_base_cnt;
   logic [1:0]       pred_ext_cnt;
   name_type         pred_name;

   name_beat_type    pending_name_beats[$];
   int               error_count = 0;
   int               sent_count = 0;
   int               burst_left = 0;
   bit               gaps_on = 1'b0;
   logic [15:0]      rx_tick = 16'd0;
   int               quiet_cycles = 0;

   fat_short_name_formatter_unit #(
      .BASE_LEN(BASE_LEN),
      .EXT_LEN (EXT_LEN)
   ) u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_name_byte      (req_name_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_short_name_byte(rsp_short_name_byte),
      .rsp_byte_position  (rsp_byte_position),
      .rsp_last_byte      (rsp_last_byte)
   );

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Lower-case letters fold to upper case; all other codes pass through.
   function automatic logic [7:0] fold_case(input logic [7:0] c);
      if (c >= LOWER_A && c <= LOWER_Z) begin
         return c - CASE_DIFF;
      end
      return c;
   endfunction

   task automatic clear_prediction();
      pred_phase    = PH_BASE;
      pred_base_cnt = '0;
      pred_ext_cnt  = '0;
      for (int k = 0; k < NAME_BYTES; k++) begin
         pred_name[k] = SPACE_CODE;
      end
   endtask

   // Advances the predicted state by one accepted name byte.
   task automatic predict_name_byte(input logic [7:0] c);
      name_beat_type beat;
      if (c == END_CODE) begin
         for (int k = 0; k < NAME_BYTES; k++) begin
            beat.char_code = pred_name[k];
            beat.position  = POS_W'(k);
            beat.last      = (k == NAME_BYTES - 1);
            pending_name_beats.push_back(beat);
         end
         clear_prediction();
      end else begin
         case (pred_phase)
            PH_BASE: begin
               if (c == DOT_CODE) begin
                  pred_phase = PH_EXT;
               end else if (c == SPACE_CODE) begin
                  pred_phase = PH_DONE;
               end else if (pred_base_cnt < BASE_LEN && pred_base_cnt < EXT_START) begin
                  pred_name[pred_base_cnt] = fold_case(c);
                  pred_base_cnt++;
               end
            end
            PH_EXT: begin
               if (c == SPACE_CODE) begin
                  pred_phase = PH_DONE;
               end else if (pred_ext_cnt < EXT_LEN
                            && pred_ext_cnt < NAME_BYTES - EXT_START) begin
                  pred_name[EXT_START + pred_ext_cnt] = fold_case(c);
                  pred_ext_cnt++;
                  if (pred_ext_cnt >= EXT_LEN) begin
                     pred_phase = PH_DONE;
                  end
               end else begin
                  pred_phase = PH_DONE;
               end
            end
            default: ;
         endcase
      end
   endtask

   task automatic flag_error(input string what);
      error_count++;
      if (error_count <= 10) begin
         $display("ERROR at %0t ns: %s", $time, what);
      end
   endtask

   // Sends one byte, in bursts with random gaps when gaps are enabled.
   task automatic send_name_byte(input logic [7:0] c);
      int gap;
      if (gaps_on && burst_left <= 0) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
      req_valid     <= 1'b1;
      req_name_byte <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_name_byte(c);
      sent_count++;
      burst_left--;
   endtask

   function automatic logic [7:0] random_name_char();
      case ($urandom_range(0, 7))
         0, 1, 2, 3: return 8'($urandom_range(LOWER_A, LOWER_Z));
         4:          return 8'($urandom_range(8'h41, 8'h5A));
         5:          return 8'($urandom_range(8'h30, 8'h39));
         default:    return 8'($urandom_range(1, 255));
      endcase
   endfunction

   // A mostly well-formed name with random content, closed by an end byte.
   task automatic send_random_name();
      int base_len;
      int ext_len;
      int tail_len;
      int shape;
      base_len = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 8);
      ext_len  = $urandom_range(0, 4);
      tail_len = $urandom_range(0, 3);
      shape    = $urandom_range(0, 7);
      repeat (base_len) send_name_byte(random_name_char());
      if (shape <= 4 || shape == 6) begin
         send_name_byte(DOT_CODE);
         repeat (ext_len) send_name_byte(random_name_char());
      end
      if (shape == 5 || shape == 6) begin
         send_name_byte(SPACE_CODE);
         repeat (tail_len) send_name_byte(random_name_char());
      end
      send_name_byte(END_CODE);
   endtask

   // Corner names: empty name, case fold limits, high codes, overlong base,
   // dot inside the extension, full extension, spaces in both parts.
   task automatic test_directed_names();
      logic [7:0] corner_bytes[$] = '{
         8'h00,
         8'h60, 8'h61, 8'h7A, 8'h7B, 8'h80, 8'hFF, 8'h01, 8'h41, 8'h71,
         8'h2E, 8'h62, 8'h2E, 8'h63, 8'h64, 8'h00,
         8'h78, 8'h20, 8'h79, 8'h00,
         8'h2E, 8'h65, 8'h20, 8'h66, 8'h00
      };
      gaps_on = 1'b0;
      foreach (corner_bytes[i]) send_name_byte(corner_bytes[i]);
   endtask

   task automatic test_random_names();
      gaps_on = 1'b1;
      while (sent_count < 280) send_random_name();
   endtask

   // Unstructured bytes, with frequent end bytes.
   task automatic test_noise_bytes();
      gaps_on = 1'b1;
      repeat (40) begin
         if ($urandom_range(0, 5) == 0) begin
            send_name_byte(END_CODE);
         end else begin
            send_name_byte(8'($urandom_range(1, 255)));
         end
      end
      send_name_byte(END_CODE);
   endtask

   // Empty names back to back press on the emission side.
   task automatic test_back_to_back_ends();
      gaps_on = 1'b0;
      repeat (12) send_name_byte(END_CODE);
   endtask

   task automatic test_streaming_names();
      gaps_on = 1'b0;
      while (sent_count < TOTAL_BYTES) send_random_name();
   endtask

   // Receiver: free-flowing, random and periodic stall windows.
   always @(posedge clock) begin
      rx_tick <= rx_tick + 16'd1;
      if (rx_tick[6:0] < 7'd40) begin
         rsp_stall <= 1'b0;
      end else if (rx_tick[6:0] < 7'd80) begin
         rsp_stall <= ($urandom_range(0, 1) == 1);
      end else begin
         rsp_stall <= (rx_tick[2:0] < 3'd3);
      end
   end

   // Compares each accepted result beat with the oldest predicted byte.
   always @(posedge clock) begin : check_name_beats
      name_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_name_beats.size() == 0) begin
            flag_error($sformatf("unexpected beat: byte %h pos %0d last %b",
                                 rsp_short_name_byte, rsp_byte_position, rsp_last_byte));
         end else begin
            want = pending_name_beats.pop_front();
            if (rsp_short_name_byte !== want.char_code || rsp_byte_position !== want.position
                || rsp_last_byte !== want.last) begin
               flag_error($sformatf("beat mismatch: want byte %h pos %0d last %b, got %h %0d %b",
                                    want.char_code, want.position, want.last,
                                    rsp_short_name_byte, rsp_byte_position, rsp_last_byte));
            end
         end
      end
   end

   // Watchdog: ends the run when no beat moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   // Test sequence.
   initial begin
      clear_prediction();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed_names();
      test_random_names();
      test_noise_bytes();
      test_back_to_back_ends();
      test_streaming_names();
      req_valid <= 1'b0;
      while (pending_name_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
